// ----- rtl/core/bdhr_pkg.sv -----
package bdhr_pkg;

    localparam int TIME_BITS = 32;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [2:0] {
        CMD_TOGGLE_WIFI   = 3'd0,
        CMD_RESET_WIFI    = 3'd1,
        CMD_ADJUST_FAN    = 3'd2,
        CMD_TOGGLE_LIGHTS = 3'd3,
        CMD_TOGGLE_POWER  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_DEBOUNCE    = 3'd0,
        CFG_MIDDLE_HOLD = 3'd1,
        CFG_POWER_HOLD  = 3'd2,
        CFG_RPT_DELAY   = 3'd3,
        CFG_RPT_INTERVAL= 3'd4,
        CFG_FAN_STEP    = 3'd5,
        CFG_IDLE_LEVELS = 3'd6
    } t_cfg_idx;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd40;
    localparam logic [15:0] MIDDLE_HOLD_RST  = 16'd3000;
    localparam logic [15:0] POWER_HOLD_RST   = 16'd8000;
    localparam logic [15:0] RPT_DELAY_RST    = 16'd500;
    localparam logic [15:0] RPT_INTERVAL_RST = 16'd150;
    localparam logic [6:0]  FAN_STEP_RST     = 7'd5;
    localparam logic [3:0]  IDLE_LEVELS_RST  = 4'd0;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [3:0]  pin_levels;
    } t_in_word;

    typedef struct packed {
        t_cmd              command;
        logic signed [7:0] fan_delta;
    } t_out_word;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] middle_hold_ms;
        logic [15:0] power_hold_ms;
        logic [15:0] repeat_delay_ms;
        logic [15:0] repeat_interval_ms;
        logic [6:0]  fan_step;
        logic [3:0]  idle_levels;
    } t_cfg;

    typedef struct packed {
        logic  stable;
        t_time change_time;
        t_time repeat_due;
    } t_fan_st;

    typedef struct packed {
        logic  stable;
        t_time change_time;
        t_time hold_start;
        logic  hold_fired;
    } t_hold_st;

    typedef struct packed {
        logic    emit;
        t_fan_st st;
    } t_fan_res;

    typedef struct packed {
        logic     emit;
        logic     is_long;
        t_hold_st st;
    } t_hold_res;

endpackage

// ----- rtl/core/bdhr_cfg.sv -----
module bdhr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output bdhr_pkg::t_cfg o_cfg
);

    bdhr_pkg::t_cfg r_cfg;
    bdhr_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (bdhr_pkg::t_cfg_idx'(i_cfg_index))
                bdhr_pkg::CFG_DEBOUNCE:     n_cfg.debounce_ms        = i_cfg_data;
                bdhr_pkg::CFG_MIDDLE_HOLD:  n_cfg.middle_hold_ms     = i_cfg_data;
                bdhr_pkg::CFG_POWER_HOLD:   n_cfg.power_hold_ms      = i_cfg_data;
                bdhr_pkg::CFG_RPT_DELAY:    n_cfg.repeat_delay_ms    = i_cfg_data;
                bdhr_pkg::CFG_RPT_INTERVAL: n_cfg.repeat_interval_ms = i_cfg_data;
                bdhr_pkg::CFG_FAN_STEP:     n_cfg.fan_step           = i_cfg_data[6:0];
                bdhr_pkg::CFG_IDLE_LEVELS:  n_cfg.idle_levels        = i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= bdhr_pkg::DEBOUNCE_RST;
            r_cfg.middle_hold_ms     <= bdhr_pkg::MIDDLE_HOLD_RST;
            r_cfg.power_hold_ms      <= bdhr_pkg::POWER_HOLD_RST;
            r_cfg.repeat_delay_ms    <= bdhr_pkg::RPT_DELAY_RST;
            r_cfg.repeat_interval_ms <= bdhr_pkg::RPT_INTERVAL_RST;
            r_cfg.fan_step           <= bdhr_pkg::FAN_STEP_RST;
            r_cfg.idle_levels        <= bdhr_pkg::IDLE_LEVELS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/bdhr_fan_btn.sv -----
module bdhr_fan_btn (
    input  logic              i_lvl,
    input  logic              i_idle,
    input  bdhr_pkg::t_time   i_now,
    input  bdhr_pkg::t_cfg    i_cfg,
    input  bdhr_pkg::t_fan_st i_st,
    output bdhr_pkg::t_fan_res o_res
);

    logic            raw_p;
    logic            deb_p;
    bdhr_pkg::t_time due_diff;
    bdhr_pkg::t_time chg_diff;

    assign raw_p    = i_lvl != i_idle;
    assign deb_p    = i_st.stable != i_idle;
    assign due_diff = i_now - i_st.repeat_due;
    assign chg_diff = i_now - i_st.change_time;

    always_comb begin
        o_res.emit = 1'b0;
        o_res.st   = i_st;
        if (raw_p && deb_p && !due_diff[bdhr_pkg::TIME_BITS-1]) begin
            o_res.emit          = 1'b1;
            o_res.st.repeat_due = i_now + bdhr_pkg::t_time'(i_cfg.repeat_interval_ms);
        end else if (i_lvl != i_st.stable &&
                     chg_diff >= bdhr_pkg::t_time'(i_cfg.debounce_ms)) begin
            o_res.st.change_time = i_now;
            o_res.st.stable      = i_lvl;
            if (raw_p) begin
                o_res.emit          = 1'b1;
                o_res.st.repeat_due = i_now + bdhr_pkg::t_time'(i_cfg.repeat_delay_ms);
            end
        end
    end

endmodule

// ----- rtl/core/bdhr_hold_btn.sv -----
module bdhr_hold_btn (
    input  logic               i_lvl,
    input  logic               i_idle,
    input  bdhr_pkg::t_time    i_now,
    input  logic [15:0]        i_hold_ms,
    input  logic [15:0]        i_debounce_ms,
    input  bdhr_pkg::t_hold_st i_st,
    output bdhr_pkg::t_hold_res o_res
);

    logic            raw_p;
    logic            deb_p;
    bdhr_pkg::t_time hs;
    bdhr_pkg::t_time held;
    bdhr_pkg::t_time chg_diff;

    assign raw_p    = i_lvl != i_idle;
    assign deb_p    = i_st.stable != i_idle;
    // hold timer restarts while pressed but not yet debounced
    assign hs       = (raw_p && !deb_p && i_st.hold_start <= i_st.change_time) ?
                      i_now : i_st.hold_start;
    assign held     = i_now - hs;
    assign chg_diff = i_now - i_st.change_time;

    always_comb begin
        o_res.emit          = 1'b0;
        o_res.is_long       = 1'b0;
        o_res.st            = i_st;
        o_res.st.hold_start = hs;
        if (raw_p && !i_st.hold_fired && held >= bdhr_pkg::t_time'(i_hold_ms)) begin
            o_res.emit          = 1'b1;
            o_res.is_long       = 1'b1;
            o_res.st.hold_fired = 1'b1;
        end else if (i_lvl != i_st.stable &&
                     chg_diff >= bdhr_pkg::t_time'(i_debounce_ms)) begin
            o_res.st.change_time = i_now;
            o_res.st.stable      = i_lvl;
            if (raw_p) begin
                o_res.st.hold_start = i_now;
                o_res.st.hold_fired = 1'b0;
            end else if (!i_st.hold_fired) begin
                o_res.emit = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/button_debounce_hold_repeat_top.sv -----
// An accepted poll word is held in the input register r_in, and its result goes to the output register r_out.
// Throughput: one poll word per cycle while the output is not stalled; the four buttons are evaluated in parallel
// with a priority pick, and button state is written back in that same cycle.
// A poll that yields no command produces no output word.
// Reset (synchronous, active low): valid flags and config registers return to defaults, button state clears.
module button_debounce_hold_repeat_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bdhr_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bdhr_pkg::t_out_word o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    bdhr_pkg::t_cfg      cfg;
    bdhr_pkg::t_in_word  r_in;
    logic                r_in_valid;
    bdhr_pkg::t_out_word r_out;
    logic                r_out_valid;
    bdhr_pkg::t_out_word n_out;
    bdhr_pkg::t_fan_st   r_fan [2];
    bdhr_pkg::t_hold_st  r_hold [2];
    bdhr_pkg::t_fan_res  fan_res [2];
    bdhr_pkg::t_hold_res hold_res [2];
    bdhr_pkg::t_time     now;
    logic                adv;
    logic                fire;
    logic                take;
    logic                any_emit;
    logic [3:0]          upd;

    bdhr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign now = bdhr_pkg::t_time'(r_in.now_ms);

    bdhr_fan_btn u_up (
        .i_lvl  (r_in.pin_levels[0]),
        .i_idle (cfg.idle_levels[0]),
        .i_now  (now),
        .i_cfg  (cfg),
        .i_st   (r_fan[0]),
        .o_res  (fan_res[0])
    );

    bdhr_fan_btn u_down (
        .i_lvl  (r_in.pin_levels[1]),
        .i_idle (cfg.idle_levels[1]),
        .i_now  (now),
        .i_cfg  (cfg),
        .i_st   (r_fan[1]),
        .o_res  (fan_res[1])
    );

    bdhr_hold_btn u_middle (
        .i_lvl         (r_in.pin_levels[2]),
        .i_idle        (cfg.idle_levels[2]),
        .i_now         (now),
        .i_hold_ms     (cfg.middle_hold_ms),
        .i_debounce_ms (cfg.debounce_ms),
        .i_st          (r_hold[0]),
        .o_res         (hold_res[0])
    );

    bdhr_hold_btn u_power (
        .i_lvl         (r_in.pin_levels[3]),
        .i_idle        (cfg.idle_levels[3]),
        .i_now         (now),
        .i_hold_ms     (cfg.power_hold_ms),
        .i_debounce_ms (cfg.debounce_ms),
        .i_st          (r_hold[1]),
        .o_res         (hold_res[1])
    );

    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;
    assign take       = i_in_valid && !o_in_stall;

    // first emitting button ends the poll; later buttons keep their state
    assign upd[0] = 1'b1;
    assign upd[1] = !fan_res[0].emit;
    assign upd[2] = upd[1] && !fan_res[1].emit;
    assign upd[3] = upd[2] && !hold_res[0].emit;
    assign any_emit = fan_res[0].emit || fan_res[1].emit ||
                      hold_res[0].emit || hold_res[1].emit;

    always_comb begin
        n_out.command   = bdhr_pkg::CMD_ADJUST_FAN;
        n_out.fan_delta = 8'sd0;
        if (fan_res[0].emit) begin
            n_out.fan_delta = $signed({1'b0, cfg.fan_step});
        end else if (fan_res[1].emit) begin
            n_out.fan_delta = -$signed({1'b0, cfg.fan_step});
        end else if (hold_res[0].emit) begin
            n_out.command = hold_res[0].is_long ? bdhr_pkg::CMD_TOGGLE_WIFI :
                                                  bdhr_pkg::CMD_TOGGLE_LIGHTS;
        end else begin
            n_out.command = hold_res[1].is_long ? bdhr_pkg::CMD_RESET_WIFI :
                                                  bdhr_pkg::CMD_TOGGLE_POWER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && any_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && any_emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan[0]  <= '0;
            r_fan[1]  <= '0;
            r_hold[0] <= '0;
            r_hold[1] <= '0;
        end else if (fire) begin
            if (upd[0]) begin
                r_fan[0] <= fan_res[0].st;
            end
            if (upd[1]) begin
                r_fan[1] <= fan_res[1].st;
            end
            if (upd[2]) begin
                r_hold[0] <= hold_res[0].st;
            end
            if (upd[3]) begin
                r_hold[1] <= hold_res[1].st;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
